FILE: rtl/stp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

	// Tableau shape. The item fields are two bits of row and three bits of
	// column wide, so the shape is fixed here.
	localparam int ROWS = 4;
	localparam int COLS = 7;

	// Index registers are sized for the largest tableau the block supports.
	typedef logic [3:0] row_idx_t;
	typedef logic [4:0] col_idx_t;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_PIVOT = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_PIVOTED   = 2'd0,
		ST_OPTIMAL   = 2'd1,
		ST_UNBOUNDED = 2'd2,
		ST_READ      = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_WRITE_IN,
		DP_LATCH_OK,
		DP_CLEAR,
		DP_OBJ_CMP,
		DP_LOAD_A,
		DP_RT_TAKE,
		DP_HOLD_RHS,
		DP_MUL1,
		DP_MUL2,
		DP_RT_CMP,
		DP_DIV_START,
		DP_NM_WRITE,
		DP_LOAD_F,
		DP_LOAD_N,
		DP_EL_MUL,
		DP_EL_WRITE,
		DP_EMIT_READ,
		DP_EMIT_OPT,
		DP_EMIT_UNB,
		DP_EMIT_PIV
	} dp_op_t;

	typedef enum logic [1:0] {
		RS_CNT,
		RS_PR,
		RS_OBJ,
		RS_IN
	} row_sel_t;

	typedef enum logic [1:0] {
		CS_CNT,
		CS_PC,
		CS_RHS,
		CS_IN
	} col_sel_t;

	typedef struct packed {
		dp_op_t   op;
		logic     rd_en;
		row_sel_t row_sel;
		col_sel_t col_sel;
		row_idx_t i;
		col_idx_t j;
	} dp_cmd_t;

	typedef struct packed {
		logic     best_neg;
		logic     a_pos;
		logic     have_pr;
		logic     div_done;
		row_idx_t pr;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/stp_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle: (x * 2^FRAC_BITS) / d for a
// positive divisor, truncated toward zero and saturated to 32 bits signed.
module stp_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] dividend,
	input  wire logic signed [31:0] divisor,
	output logic                    busy,
	output logic signed [31:0]      quotient
);

	localparam int QW   = 32 + FRAC_BITS;
	localparam int CNTW = $clog2(QW + 1);

	logic [31:0]     rem_q;
	logic [QW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            neg_q;

	logic [31:0] mag;
	logic [32:0] sh;
	logic [32:0] dv;
	logic        ge;
	logic        over_pos;
	logic        over_neg;

	always_comb begin
		mag      = dividend[31] ? 32'(-dividend) : 32'(dividend);
		sh       = {rem_q, quo_q[QW-1]};
		dv       = {1'b0, divisor};
		ge       = (sh >= dv);
		over_pos = (|quo_q[QW-1:31]);
		over_neg = (|quo_q[QW-1:32]) || (quo_q[31] && (|quo_q[30:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= {mag, {FRAC_BITS{1'b0}}};
			neg_q <= dividend[31];
		end else if (busy_q) begin
			rem_q <= ge ? 32'(sh - dv) : sh[31:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	always_comb begin
		if (neg_q) begin
			quotient = over_neg ? 32'sh8000_0000 : 32'(-quo_q[31:0]);
		end else begin
			quotient = over_pos ? 32'sh7FFF_FFFF : 32'(quo_q[31:0]);
		end
	end

	assign busy = busy_q;

endmodule

`default_nettype wire

FILE: rtl/stp_dp.sv
`timescale 1ns / 1ps
`default_nettype none

// Tableau memory, selection registers, shared multiplier and divider.
module stp_dp #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire stp_pkg::dp_cmd_t   cmd,
	input  wire logic [1:0]         in_row,
	input  wire logic [2:0]         in_col,
	input  wire logic signed [31:0] in_value,
	output stp_pkg::dp_stat_t       st,
	output logic                    strobe,
	output logic signed [31:0]      data_out,
	output logic [1:0]              pivot_row,
	output logic [2:0]              pivot_col,
	output logic [1:0]              status
);

	localparam int ROWS  = stp_pkg::ROWS;
	localparam int COLS  = stp_pkg::COLS;
	localparam int DEPTH = ROWS * COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic signed [63:0] BIAS = 64'((64'd1 << FRAC_BITS) - 64'd1);

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		if (v > 65'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < -65'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	logic signed [31:0] mem_q [DEPTH];
	logic signed [31:0] rd_q;
	logic               rd_ok_q;

	logic signed [31:0] best_q, a_q, b_q, rhsi_q, rhspr_q, f_q, n_q;
	logic signed [63:0] prod1_q, prod2_q;
	stp_pkg::col_idx_t  pc_q;
	stp_pkg::row_idx_t  pr_q;
	logic               have_q;

	logic               strobe_q;
	logic signed [31:0] dout_q;
	logic [1:0]         prow_q;
	logic [2:0]         pcol_q;
	logic [1:0]         stat_q;

	stp_pkg::row_idx_t  row_v;
	stp_pkg::col_idx_t  col_v;
	logic [AW-1:0]      addr;
	logic               in_ok;
	logic               addr_ok;
	logic               we;
	logic signed [31:0] wdata;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_res;
	logic signed [63:0] trunc_v;
	logic signed [64:0] diff;
	logic signed [31:0] div_q;
	logic               div_busy;
	logic               emit;

	always_comb begin
		case (cmd.row_sel)
			stp_pkg::RS_CNT: row_v = cmd.i;
			stp_pkg::RS_PR:  row_v = pr_q;
			stp_pkg::RS_OBJ: row_v = stp_pkg::row_idx_t'(ROWS - 1);
			stp_pkg::RS_IN:  row_v = stp_pkg::row_idx_t'(in_row);
			default:         row_v = cmd.i;
		endcase
		case (cmd.col_sel)
			stp_pkg::CS_CNT: col_v = cmd.j;
			stp_pkg::CS_PC:  col_v = pc_q;
			stp_pkg::CS_RHS: col_v = stp_pkg::col_idx_t'(COLS - 1);
			stp_pkg::CS_IN:  col_v = stp_pkg::col_idx_t'(in_col);
			default:         col_v = cmd.j;
		endcase
		in_ok   = (32'(in_row) < ROWS) && (32'(in_col) < COLS);
		addr_ok = (cmd.row_sel != stp_pkg::RS_IN) || in_ok;
		addr    = AW'(32'(row_v) * COLS + 32'(col_v));
	end

	always_comb begin
		case (cmd.op)
			stp_pkg::DP_MUL1: begin
				mul_a = rhsi_q;
				mul_b = b_q;
			end
			stp_pkg::DP_MUL2: begin
				mul_a = rhspr_q;
				mul_b = a_q;
			end
			default: begin
				mul_a = f_q;
				mul_b = n_q;
			end
		endcase
		mul_res = mul_a * mul_b;
	end

	// Product scaled back to Q format with truncation toward zero.
	always_comb begin
		trunc_v = prod1_q[63] ? ((prod1_q + BIAS) >>> FRAC_BITS) : (prod1_q >>> FRAC_BITS);
		diff    = 65'(a_q) - 65'(trunc_v);
	end

	always_comb begin
		case (cmd.op)
			stp_pkg::DP_WRITE_IN: wdata = in_value;
			stp_pkg::DP_NM_WRITE: wdata = div_q;
			default:              wdata = sat32(diff);
		endcase
		we = addr_ok && (cmd.op inside {stp_pkg::DP_WRITE_IN, stp_pkg::DP_NM_WRITE,
			stp_pkg::DP_EL_WRITE});
		emit = cmd.op inside {stp_pkg::DP_EMIT_READ, stp_pkg::DP_EMIT_OPT,
			stp_pkg::DP_EMIT_UNB, stp_pkg::DP_EMIT_PIV};
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (cmd.rd_en && addr_ok) begin
			rd_q <= mem_q[addr];
		end
	end

	stp_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.op == stp_pkg::DP_DIV_START),
		.dividend(rd_q),
		.divisor (b_q),
		.busy    (div_busy),
		.quotient(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (cmd.op == stp_pkg::DP_CLEAR) begin
				have_q <= 1'b0;
			end else if (cmd.op == stp_pkg::DP_RT_TAKE) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			stp_pkg::DP_LATCH_OK: rd_ok_q <= in_ok;
			stp_pkg::DP_OBJ_CMP: begin
				if ((cmd.j == '0) || (rd_q < best_q)) begin
					best_q <= rd_q;
					pc_q   <= cmd.j;
				end
			end
			stp_pkg::DP_LOAD_A: a_q <= rd_q;
			stp_pkg::DP_RT_TAKE: begin
				pr_q    <= cmd.i;
				b_q     <= a_q;
				rhspr_q <= rd_q;
			end
			stp_pkg::DP_HOLD_RHS: rhsi_q <= rd_q;
			stp_pkg::DP_MUL1: prod1_q <= mul_res;
			stp_pkg::DP_MUL2: prod2_q <= mul_res;
			stp_pkg::DP_RT_CMP: begin
				if (prod1_q < prod2_q) begin
					pr_q    <= cmd.i;
					b_q     <= a_q;
					rhspr_q <= rhsi_q;
				end
			end
			stp_pkg::DP_LOAD_F: f_q <= rd_q;
			stp_pkg::DP_LOAD_N: n_q <= rd_q;
			stp_pkg::DP_EL_MUL: begin
				a_q     <= rd_q;
				prod1_q <= mul_res;
			end
			stp_pkg::DP_EMIT_READ: begin
				dout_q <= rd_ok_q ? rd_q : 32'sd0;
				prow_q <= '0;
				pcol_q <= '0;
				stat_q <= stp_pkg::ST_READ;
			end
			stp_pkg::DP_EMIT_OPT: begin
				dout_q <= 32'sd0;
				prow_q <= '0;
				pcol_q <= '0;
				stat_q <= stp_pkg::ST_OPTIMAL;
			end
			stp_pkg::DP_EMIT_UNB: begin
				dout_q <= 32'sd0;
				prow_q <= '0;
				pcol_q <= pc_q[2:0];
				stat_q <= stp_pkg::ST_UNBOUNDED;
			end
			stp_pkg::DP_EMIT_PIV: begin
				dout_q <= b_q;
				prow_q <= pr_q[1:0];
				pcol_q <= pc_q[2:0];
				stat_q <= stp_pkg::ST_PIVOTED;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		st.best_neg = best_q[31];
		st.a_pos    = !a_q[31] && (|a_q);
		st.have_pr  = have_q;
		st.div_done = !div_busy;
		st.pr       = pr_q;
	end

	assign strobe    = strobe_q;
	assign data_out  = dout_q;
	assign pivot_row = prow_q;
	assign pivot_col = pcol_q;
	assign status    = stat_q;

endmodule

`default_nettype wire

FILE: rtl/stp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer for load, read and one pivot iteration.
module stp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        mode,
	input  wire stp_pkg::dp_stat_t st,
	output logic                   busy,
	output stp_pkg::dp_cmd_t       cmd
);

	typedef enum logic [21:0] {
		S_IDLE    = 22'd1 << 0,
		S_RD      = 22'd1 << 1,
		S_OBJ_RD  = 22'd1 << 2,
		S_OBJ_CMP = 22'd1 << 3,
		S_OBJ_END = 22'd1 << 4,
		S_RT_A    = 22'd1 << 5,
		S_RT_AW   = 22'd1 << 6,
		S_RT_R    = 22'd1 << 7,
		S_RT_M1   = 22'd1 << 8,
		S_RT_M2   = 22'd1 << 9,
		S_RT_C    = 22'd1 << 10,
		S_RT_END  = 22'd1 << 11,
		S_NM_RD   = 22'd1 << 12,
		S_NM_DIV  = 22'd1 << 13,
		S_NM_WAIT = 22'd1 << 14,
		S_EL_F    = 22'd1 << 15,
		S_EL_FW   = 22'd1 << 16,
		S_EL_RN   = 22'd1 << 17,
		S_EL_RA   = 22'd1 << 18,
		S_EL_MUL  = 22'd1 << 19,
		S_EL_WR   = 22'd1 << 20,
		S_EMIT    = 22'd1 << 21
	} state_t;

	localparam int ROWS = stp_pkg::ROWS;
	localparam int COLS = stp_pkg::COLS;
	localparam stp_pkg::row_idx_t LAST_CON = stp_pkg::row_idx_t'(ROWS - 2);
	localparam stp_pkg::row_idx_t LAST_ROW = stp_pkg::row_idx_t'(ROWS - 1);
	localparam stp_pkg::col_idx_t LAST_VAR = stp_pkg::col_idx_t'(COLS - 2);
	localparam stp_pkg::col_idx_t LAST_COL = stp_pkg::col_idx_t'(COLS - 1);

	state_t            state_q, state_d;
	stp_pkg::row_idx_t i_q, i_d;
	stp_pkg::col_idx_t j_q, j_d;

	always_comb begin
		state_d     = state_q;
		i_d         = i_q;
		j_d         = j_q;
		cmd.op      = stp_pkg::DP_NOP;
		cmd.rd_en   = 1'b0;
		cmd.row_sel = stp_pkg::RS_CNT;
		cmd.col_sel = stp_pkg::CS_CNT;
		cmd.i       = i_q;
		cmd.j       = j_q;
		case (state_q)
			S_IDLE: begin
				cmd.row_sel = stp_pkg::RS_IN;
				cmd.col_sel = stp_pkg::CS_IN;
				if (start) begin
					case (mode)
						stp_pkg::MODE_WRITE: cmd.op = stp_pkg::DP_WRITE_IN;
						stp_pkg::MODE_READ: begin
							cmd.op    = stp_pkg::DP_LATCH_OK;
							cmd.rd_en = 1'b1;
							state_d   = S_RD;
						end
						stp_pkg::MODE_PIVOT: begin
							cmd.op  = stp_pkg::DP_CLEAR;
							j_d     = '0;
							state_d = S_OBJ_RD;
						end
						default: begin
						end
					endcase
				end
			end
			S_RD: begin
				cmd.op  = stp_pkg::DP_EMIT_READ;
				state_d = S_IDLE;
			end
			S_OBJ_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.row_sel = stp_pkg::RS_OBJ;
				state_d     = S_OBJ_CMP;
			end
			S_OBJ_CMP: begin
				cmd.op = stp_pkg::DP_OBJ_CMP;
				if (j_q == LAST_VAR) begin
					state_d = S_OBJ_END;
				end else begin
					j_d     = j_q + stp_pkg::col_idx_t'(1);
					state_d = S_OBJ_RD;
				end
			end
			S_OBJ_END: begin
				if (!st.best_neg) begin
					cmd.op  = stp_pkg::DP_EMIT_OPT;
					state_d = S_IDLE;
				end else begin
					i_d     = '0;
					state_d = S_RT_A;
				end
			end
			S_RT_A: begin
				cmd.rd_en   = 1'b1;
				cmd.col_sel = stp_pkg::CS_PC;
				state_d     = S_RT_AW;
			end
			S_RT_AW: begin
				cmd.op      = stp_pkg::DP_LOAD_A;
				cmd.rd_en   = 1'b1;
				cmd.col_sel = stp_pkg::CS_RHS;
				state_d     = S_RT_R;
			end
			S_RT_R: begin
				if (st.a_pos && st.have_pr) begin
					cmd.op  = stp_pkg::DP_HOLD_RHS;
					state_d = S_RT_M1;
				end else begin
					if (st.a_pos) begin
						cmd.op = stp_pkg::DP_RT_TAKE;
					end
					if (i_q == LAST_CON) begin
						state_d = S_RT_END;
					end else begin
						i_d     = i_q + stp_pkg::row_idx_t'(1);
						state_d = S_RT_A;
					end
				end
			end
			S_RT_M1: begin
				cmd.op  = stp_pkg::DP_MUL1;
				state_d = S_RT_M2;
			end
			S_RT_M2: begin
				cmd.op  = stp_pkg::DP_MUL2;
				state_d = S_RT_C;
			end
			S_RT_C: begin
				cmd.op = stp_pkg::DP_RT_CMP;
				if (i_q == LAST_CON) begin
					state_d = S_RT_END;
				end else begin
					i_d     = i_q + stp_pkg::row_idx_t'(1);
					state_d = S_RT_A;
				end
			end
			S_RT_END: begin
				if (!st.have_pr) begin
					cmd.op  = stp_pkg::DP_EMIT_UNB;
					state_d = S_IDLE;
				end else begin
					j_d     = '0;
					state_d = S_NM_RD;
				end
			end
			S_NM_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.row_sel = stp_pkg::RS_PR;
				state_d     = S_NM_DIV;
			end
			S_NM_DIV: begin
				cmd.op  = stp_pkg::DP_DIV_START;
				state_d = S_NM_WAIT;
			end
			S_NM_WAIT: begin
				cmd.row_sel = stp_pkg::RS_PR;
				if (st.div_done) begin
					cmd.op = stp_pkg::DP_NM_WRITE;
					if (j_q == LAST_COL) begin
						i_d     = '0;
						state_d = S_EL_F;
					end else begin
						j_d     = j_q + stp_pkg::col_idx_t'(1);
						state_d = S_NM_RD;
					end
				end
			end
			S_EL_F: begin
				if (i_q == st.pr) begin
					if (i_q == LAST_ROW) begin
						state_d = S_EMIT;
					end else begin
						i_d = i_q + stp_pkg::row_idx_t'(1);
					end
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.col_sel = stp_pkg::CS_PC;
					state_d     = S_EL_FW;
				end
			end
			S_EL_FW: begin
				cmd.op  = stp_pkg::DP_LOAD_F;
				j_d     = '0;
				state_d = S_EL_RN;
			end
			S_EL_RN: begin
				cmd.rd_en   = 1'b1;
				cmd.row_sel = stp_pkg::RS_PR;
				state_d     = S_EL_RA;
			end
			S_EL_RA: begin
				cmd.op    = stp_pkg::DP_LOAD_N;
				cmd.rd_en = 1'b1;
				state_d   = S_EL_MUL;
			end
			S_EL_MUL: begin
				cmd.op  = stp_pkg::DP_EL_MUL;
				state_d = S_EL_WR;
			end
			S_EL_WR: begin
				cmd.op = stp_pkg::DP_EL_WRITE;
				if (j_q != LAST_COL) begin
					j_d     = j_q + stp_pkg::col_idx_t'(1);
					state_d = S_EL_RN;
				end else if (i_q == LAST_ROW) begin
					state_d = S_EMIT;
				end else begin
					i_d     = i_q + stp_pkg::row_idx_t'(1);
					state_d = S_EL_F;
				end
			end
			S_EMIT: begin
				cmd.op  = stp_pkg::DP_EMIT_PIV;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	a_pivot_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start && mode == stp_pkg::MODE_PIVOT) |=> (state_q == S_OBJ_RD))
		else $error("pivot item did not start the objective scan");

	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NM_WAIT && !st.div_done) |=> (state_q == S_NM_WAIT))
		else $error("normalization left before the divider finished");

	a_skip_pivot_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EL_WR) |-> (i_q != st.pr))
		else $error("elimination wrote into the pivot row");

	a_ratio_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RT_A) |-> (i_q <= LAST_CON))
		else $error("ratio test reached the objective row");

endmodule

`default_nettype wire

FILE: rtl/simplex_tableau_pivot_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Simplex tableau pivot engine. An item is accepted on a clock edge where start
// is high and busy is low. A write item (mode 0) stores value at row_index,
// col_index while busy stays low; it gives no result. A read item (mode 2)
// raises busy, and its result appears in the same cycle that busy falls again.
// A pivot item (mode 1) runs one simplex iteration: an objective-row scan over
// the variable columns, a ratio test over the constraint rows, normalization
// of the pivot row, in which each column is fetched, divided by the restoring
// divider and written back, and which dominates, and elimination of the other
// rows. Entries are Q16.16 with the default FRAC_BITS; optimal and unbounded
// outcomes end after the scan or ratio test. Every result is shown for exactly
// one cycle with strobe high and must be captured then: the block cannot be
// stalled. The tableau shape is fixed at 4 rows by 7 columns in stp_pkg to fit
// the index field widths. Tableau entries have no reset value and must be
// written before being read.
module simplex_tableau_pivot_top #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         mode,
	input  wire logic [1:0]         row_index,
	input  wire logic [2:0]         col_index,
	input  wire logic signed [31:0] value,
	output logic                    strobe,
	output logic signed [31:0]      data_out,
	output logic [1:0]              pivot_row,
	output logic [2:0]              pivot_col,
	output logic [1:0]              status
);

	// Command and status between the sequencer and the datapath.
	stp_pkg::dp_cmd_t  cmd;
	stp_pkg::dp_stat_t st;

	stp_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.mode  (mode),
		.st    (st),
		.busy  (busy),
		.cmd   (cmd)
	);

	stp_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_row   (row_index),
		.in_col   (col_index),
		.in_value (value),
		.st       (st),
		.strobe   (strobe),
		.data_out (data_out),
		.pivot_row(pivot_row),
		.pivot_col(pivot_col),
		.status   (status)
	);

endmodule

`default_nettype wire
